@@ src/ccre_pkg.sv @@
// Shared types, codes and constants of the character canvas raster engine.
package ccre_pkg;

    localparam int CANVAS_DIM_DEF = 64;
    localparam int CW             = 8;
    localparam int DW             = 16;
    localparam int D2W            = 14;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    typedef enum logic [2:0] {
        FN_SET    = 3'd0,
        FN_READ   = 3'd1,
        FN_LINE   = 3'd2,
        FN_RECT   = 3'd3,
        FN_FILL   = 3'd4,
        FN_CIRCLE = 3'd5,
        FN_DISC   = 3'd6,
        FN_CLEAR  = 3'd7
    } func_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_LINE,
        ST_SCAN,
        ST_READ,
        ST_RWAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        func_t       func;
        logic [5:0]  x_a;
        logic [5:0]  y_a;
        logic [5:0]  x_b;
        logic [5:0]  y_b;
        logic [5:0]  radius;
        logic [7:0]  ink;
    } cmd_t;

    typedef struct packed {
        logic start;
        logic take;
    } ctrl_t;

    typedef struct packed {
        logic       idle;
        logic       done;
        logic [7:0] result;
    } stat_t;

    typedef struct packed {
        func_t                func;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] bx0;
        logic signed [CW-1:0] bx1;
        logic signed [CW-1:0] by0;
        logic signed [CW-1:0] by1;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [5:0]           radius;
    } hit_req_t;

    typedef struct packed {
        logic mark;
        logic on_canvas;
    } hit_rsp_t;

endpackage

@@ src/ccre_store.sv @@
// Cell memory: one write port and one registered read port.
module ccre_store #(
    parameter int CANVAS_DIM = ccre_pkg::CANVAS_DIM_DEF
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [$clog2(CANVAS_DIM*CANVAS_DIM)-1:0]  waddr,
    input  logic [7:0]                                wdata,
    input  logic                                      re,
    input  logic [$clog2(CANVAS_DIM*CANVAS_DIM)-1:0]  raddr,
    output logic [7:0]                                rdata
);
    localparam int DEPTH = CANVAS_DIM * CANVAS_DIM;

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/ccre_hit.sv @@
// Shared cell test unit: shape hit compare, canvas clip and cell address.
module ccre_hit #(
    parameter int CANVAS_DIM = ccre_pkg::CANVAS_DIM_DEF
) (
    input  ccre_pkg::hit_req_t                        req,
    output ccre_pkg::hit_rsp_t                        rsp,
    output logic [$clog2(CANVAS_DIM*CANVAS_DIM)-1:0]  addr
);
    import ccre_pkg::*;

    localparam int AW = $clog2(CANVAS_DIM * CANVAS_DIM);
    localparam logic [8:0] DIM9 = 9'(CANVAS_DIM);

    logic signed [CW-1:0]   di;
    logic signed [CW-1:0]   dj;
    logic signed [2*CW-1:0] sq_i;
    logic signed [2*CW-1:0] sq_j;
    logic [D2W-1:0]         d2;
    logic [D2W-1:0]         lo;
    logic [D2W-1:0]         hi;
    logic [6:0]             r1;
    logic                   on_border;
    logic                   shape_hit;
    logic                   x_in;
    logic                   y_in;

    always_comb
    begin
        di   = req.x - req.cx;
        dj   = req.y - req.cy;
        sq_i = di * di;
        sq_j = dj * dj;
        d2   = sq_i[D2W-1:0] + sq_j[D2W-1:0];
        lo   = D2W'(req.radius) * D2W'(req.radius);
        r1   = 7'(req.radius) + 7'd1;
        hi   = D2W'(r1) * D2W'(r1);

        on_border = (req.x == req.bx0) || (req.x == req.bx1)
                 || (req.y == req.by0) || (req.y == req.by1);

        case (req.func)
            FN_RECT:   shape_hit = on_border;
            FN_CIRCLE: shape_hit = (d2 >= lo) && (d2 < hi);
            FN_DISC:   shape_hit = (d2 <= lo);
            default:   shape_hit = 1'b1;
        endcase

        x_in = !req.x[CW-1] && (9'(req.x[CW-2:0]) < DIM9);
        y_in = !req.y[CW-1] && (9'(req.y[CW-2:0]) < DIM9);

        rsp.mark      = shape_hit;
        rsp.on_canvas = x_in && y_in;
        addr = AW'(req.x[CW-2:0]) * AW'(CANVAS_DIM) + AW'(req.y[CW-2:0]);
    end

endmodule

@@ src/ccre_seq.sv @@
// Command sequencer: clear sweep, line stepping, area scan and cell read.
module ccre_seq #(
    parameter int CANVAS_DIM = ccre_pkg::CANVAS_DIM_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  ccre_pkg::cmd_t                            cmd,
    input  ccre_pkg::ctrl_t                           ctrl,
    output ccre_pkg::stat_t                           stat,
    output ccre_pkg::hit_req_t                        hit_req,
    input  ccre_pkg::hit_rsp_t                        hit_rsp,
    input  logic [$clog2(CANVAS_DIM*CANVAS_DIM)-1:0]  hit_addr,
    output logic                                      store_we,
    output logic [$clog2(CANVAS_DIM*CANVAS_DIM)-1:0]  store_waddr,
    output logic [7:0]                                store_wdata,
    output logic                                      store_re,
    input  logic [7:0]                                store_rdata
);
    import ccre_pkg::*;

    localparam int AW = $clog2(CANVAS_DIM * CANVAS_DIM);
    localparam logic [AW-1:0] LAST_CELL = AW'(CANVAS_DIM * CANVAS_DIM - 1);

    state_t               state_reg, state_next;
    logic                 init_reg, init_next;
    logic [AW-1:0]        clr_cnt_reg, clr_cnt_next;
    cmd_t                 cmd_reg, cmd_next;
    logic signed [CW-1:0] cur_x_reg, cur_x_next;
    logic signed [CW-1:0] cur_y_reg, cur_y_next;
    logic signed [CW-1:0] bx0_reg, bx0_next;
    logic signed [CW-1:0] bx1_reg, bx1_next;
    logic signed [CW-1:0] by0_reg, by0_next;
    logic signed [CW-1:0] by1_reg, by1_next;
    logic signed [DW-1:0] d_reg, d_next;
    logic signed [DW-1:0] dx2_reg, dx2_next;
    logic signed [DW-1:0] dy2_reg, dy2_next;
    logic                 rd_ok_reg, rd_ok_next;
    logic [7:0]           res_reg, res_next;

    logic signed [CW-1:0] ext_xa;
    logic signed [CW-1:0] ext_ya;
    logic signed [CW-1:0] ext_xb;
    logic signed [CW-1:0] ext_yb;
    logic signed [CW-1:0] ext_rad;
    logic signed [DW-1:0] wxa;
    logic signed [DW-1:0] wya;
    logic signed [DW-1:0] wxb;
    logic signed [DW-1:0] wyb;
    logic                 empty_cmd;
    logic                 clr_last;
    logic                 line_last;
    logic                 row_last;
    logic                 scan_last;
    logic                 d_pos;

    always_comb
    begin
        ext_xa  = {{(CW-6){1'b0}}, cmd_reg.x_a};
        ext_ya  = {{(CW-6){1'b0}}, cmd_reg.y_a};
        ext_xb  = {{(CW-6){1'b0}}, cmd_reg.x_b};
        ext_yb  = {{(CW-6){1'b0}}, cmd_reg.y_b};
        ext_rad = {{(CW-6){1'b0}}, cmd_reg.radius};
        wxa     = DW'(cmd_reg.x_a);
        wya     = DW'(cmd_reg.y_a);
        wxb     = DW'(cmd_reg.x_b);
        wyb     = DW'(cmd_reg.y_b);

        case (cmd_reg.func) inside
            FN_LINE:         empty_cmd = (cmd_reg.x_b < cmd_reg.x_a);
            FN_RECT, FN_FILL: empty_cmd = (cmd_reg.x_b < cmd_reg.x_a)
                                      || (cmd_reg.y_b < cmd_reg.y_a);
            default:         empty_cmd = 1'b0;
        endcase

        clr_last  = (clr_cnt_reg == LAST_CELL);
        line_last = (cur_x_reg == bx1_reg);
        row_last  = (cur_y_reg == by1_reg);
        scan_last = row_last && (cur_x_reg == bx1_reg);
        d_pos     = !d_reg[DW-1] && (d_reg != '0);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = init_reg ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (empty_cmd)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    unique case (cmd_reg.func) inside
                        FN_SET, FN_LINE:                   state_next = ST_LINE;
                        FN_READ:                           state_next = ST_READ;
                        FN_RECT, FN_FILL, FN_CIRCLE, FN_DISC: state_next = ST_SCAN;
                        FN_CLEAR:                          state_next = ST_CLEAR;
                        default:                           state_next = ST_DONE;
                    endcase
                end
            end
            ST_LINE:
            begin
                if (line_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:  state_next = ST_RWAIT;
            ST_RWAIT: state_next = ST_DONE;
            ST_DONE:
            begin
                if (ctrl.take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        init_next    = init_reg;
        clr_cnt_next = clr_cnt_reg;
        cmd_next     = cmd_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        bx0_next     = bx0_reg;
        bx1_next     = bx1_reg;
        by0_next     = by0_reg;
        by1_next     = by1_reg;
        d_next       = d_reg;
        dx2_next     = dx2_reg;
        dy2_next     = dy2_reg;
        rd_ok_next   = rd_ok_reg;
        res_next     = res_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_last)
                begin
                    init_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    cmd_next = cmd;
                end
            end
            ST_START:
            begin
                res_next     = '0;
                clr_cnt_next = '0;
                dx2_next     = (wxb - wxa) <<< 1;
                dy2_next     = (wyb - wya) <<< 1;
                d_next       = ((wyb - wya) <<< 1) - (wxb - wxa);
                case (cmd_reg.func) inside
                    FN_CIRCLE, FN_DISC:
                    begin
                        bx0_next = ext_xa - ext_rad;
                        bx1_next = ext_xa + ext_rad;
                        by0_next = ext_ya - ext_rad;
                        by1_next = ext_ya + ext_rad;
                    end
                    FN_SET, FN_READ:
                    begin
                        bx0_next = ext_xa;
                        bx1_next = ext_xa;
                        by0_next = ext_ya;
                        by1_next = ext_ya;
                    end
                    default:
                    begin
                        bx0_next = ext_xa;
                        bx1_next = ext_xb;
                        by0_next = ext_ya;
                        by1_next = ext_yb;
                    end
                endcase
                case (cmd_reg.func) inside
                    FN_CIRCLE, FN_DISC:
                    begin
                        cur_x_next = ext_xa - ext_rad;
                        cur_y_next = ext_ya - ext_rad;
                    end
                    default:
                    begin
                        cur_x_next = ext_xa;
                        cur_y_next = ext_ya;
                    end
                endcase
            end
            ST_LINE:
            begin
                cur_x_next = cur_x_reg + CW'(1);
                if (d_pos)
                begin
                    cur_y_next = cur_y_reg + CW'(1);
                    d_next     = d_reg - dx2_reg + dy2_reg;
                end
                else
                begin
                    d_next = d_reg + dy2_reg;
                end
            end
            ST_SCAN:
            begin
                if (row_last)
                begin
                    cur_y_next = by0_reg;
                    cur_x_next = cur_x_reg + CW'(1);
                end
                else
                begin
                    cur_y_next = cur_y_reg + CW'(1);
                end
            end
            ST_READ:
            begin
                rd_ok_next = hit_rsp.on_canvas;
            end
            ST_RWAIT:
            begin
                res_next = rd_ok_reg ? store_rdata : 8'h00;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        hit_req.func   = cmd_reg.func;
        hit_req.x      = cur_x_reg;
        hit_req.y      = cur_y_reg;
        hit_req.bx0    = bx0_reg;
        hit_req.bx1    = bx1_reg;
        hit_req.by0    = by0_reg;
        hit_req.by1    = by1_reg;
        hit_req.cx     = ext_xa;
        hit_req.cy     = ext_ya;
        hit_req.radius = cmd_reg.radius;

        store_we    = 1'b0;
        store_waddr = hit_addr;
        store_wdata = cmd_reg.ink;
        store_re    = 1'b0;

        stat.idle   = 1'b0;
        stat.done   = 1'b0;
        stat.result = res_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                store_we    = 1'b1;
                store_waddr = clr_cnt_reg;
                store_wdata = SPACE_CHAR;
            end
            ST_IDLE:  stat.idle = 1'b1;
            ST_LINE, ST_SCAN:
            begin
                store_we = hit_rsp.mark && hit_rsp.on_canvas;
            end
            ST_READ:  store_re = 1'b1;
            ST_DONE:  stat.done = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            init_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        bx0_reg   <= bx0_next;
        bx1_reg   <= bx1_next;
        by0_reg   <= by0_next;
        by1_reg   <= by1_next;
        d_reg     <= d_next;
        dx2_reg   <= dx2_next;
        dy2_reg   <= dy2_next;
        rd_ok_reg <= rd_ok_next;
        res_reg   <= res_next;
    end

`ifndef SYNTHESIS
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !store_we)
        else $error("cell write while idle");

    a_start_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> (state_reg == ST_IDLE))
        else $error("command start outside idle");

    a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_RWAIT))
        else $error("read not followed by read wait");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && ctrl.take) |=> (state_reg == ST_IDLE))
        else $error("result transfer did not release sequencer");
`endif

endmodule

@@ src/character_canvas_raster_engine.sv @@
// Top level of the character canvas raster engine: command and result channels.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+------------------------------------------
//   in      | to block  | in_valid/in_stall| func, x_a, y_a, x_b, y_b, radius, ink
//   out     | from block| out_valid/out_stall | read_char
//
// A command takes its start and done states plus its cell visits, one cell per
// cycle through the shared cell test unit and the single memory write port: set 1,
// line x_b-x_a+1, rectangles (x_b-x_a+1)*(y_b-y_a+1), circles (2*radius+1)^2,
// clear CANVAS_DIM*CANVAS_DIM. After reset a clearing pass over all CANVAS_DIM*CANVAS_DIM
// cells writes spaces with in_stall high. in_stall is high from the accepted
// transfer until its result enters the output register; a stalled result waits there.
module character_canvas_raster_engine #(
    parameter int CANVAS_DIM = ccre_pkg::CANVAS_DIM_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] func,
    input  logic [5:0] x_a,
    input  logic [5:0] y_a,
    input  logic [5:0] x_b,
    input  logic [5:0] y_b,
    input  logic [5:0] radius,
    input  logic [7:0] ink,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_char
);
    import ccre_pkg::*;

    localparam int AW = $clog2(CANVAS_DIM * CANVAS_DIM);

    cmd_t          cmd;
    ctrl_t         ctrl;
    stat_t         stat;
    hit_req_t      hit_req;
    hit_rsp_t      hit_rsp;
    logic [AW-1:0] hit_addr;
    logic          store_we;
    logic [AW-1:0] store_waddr;
    logic [7:0]    store_wdata;
    logic          store_re;
    logic [7:0]    store_rdata;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    read_char_reg, read_char_next;

    always_comb
    begin
        cmd.func   = func_t'(func);
        cmd.x_a    = x_a;
        cmd.y_a    = y_a;
        cmd.x_b    = x_b;
        cmd.y_b    = y_b;
        cmd.radius = radius;
        cmd.ink    = ink;

        in_stall   = !stat.idle;
        ctrl.start = in_valid && stat.idle;
        ctrl.take  = !out_valid_reg || !out_stall;

        out_valid_next = out_valid_reg;
        read_char_next = read_char_reg;
        if (stat.done && ctrl.take)
        begin
            out_valid_next = 1'b1;
            read_char_next = stat.result;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_char = read_char_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_char_reg <= read_char_next;
    end

    ccre_seq #(
        .CANVAS_DIM (CANVAS_DIM)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .ctrl        (ctrl),
        .stat        (stat),
        .hit_req     (hit_req),
        .hit_rsp     (hit_rsp),
        .hit_addr    (hit_addr),
        .store_we    (store_we),
        .store_waddr (store_waddr),
        .store_wdata (store_wdata),
        .store_re    (store_re),
        .store_rdata (store_rdata)
    );

    ccre_hit #(
        .CANVAS_DIM (CANVAS_DIM)
    ) u_hit (
        .req  (hit_req),
        .rsp  (hit_rsp),
        .addr (hit_addr)
    );

    ccre_store #(
        .CANVAS_DIM (CANVAS_DIM)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .re    (store_re),
        .raddr (hit_addr),
        .rdata (store_rdata)
    );

endmodule
